// ===== rtl/core/b2bcd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2bcd_pkg
// Widths, pipeline split and the shift-and-add-3 step for the BCD converter.
// ----------------------------------------------------------------------------
package b2bcd_pkg;

  localparam int BIN_W       = 32;
  localparam int OUT_W       = 32;
  // ten digits cover every 32-bit value
  localparam int BCD_DIGITS  = 10;
  localparam int BCD_W       = 4 * BCD_DIGITS;
  localparam int DIGITS      = 8;
  localparam int KEPT_DIGITS = (DIGITS < 1) ? 1 : ((DIGITS > 8) ? 8 : DIGITS);
  localparam int KEPT_W      = 4 * KEPT_DIGITS;
  localparam int STEP_BITS   = 4;
  localparam int NUM_STAGES  = BIN_W / STEP_BITS;

  typedef logic [BCD_W-1:0]     bcd_t;
  typedef logic [BIN_W-1:0]     bin_t;
  typedef logic [STEP_BITS-1:0] chunk_t;

  // STEP_BITS rounds of double dabble: adjust each digit, then shift a bit in
  function automatic bcd_t dd_step(input bcd_t bcd_in, input chunk_t bits);
    bcd_t acc;
    acc = bcd_in;
    for (int b = STEP_BITS - 1; b >= 0; b--) begin
      for (int d = 0; d < BCD_DIGITS; d++) begin
        if (acc[4*d +: 4] >= 4'd5) begin
          acc[4*d +: 4] = acc[4*d +: 4] + 4'd3;
        end
      end
      acc = {acc[BCD_W-2:0], bits[b]};
    end
    return acc;
  endfunction

endpackage

// ===== rtl/core/binary_to_bcd_core.sv =====
`timescale 1ns / 1ps
// each registered stage folds in 4 bits of the input, most significant first
// throughput: one value per cycle; each stage holds only while its successor is full and stalled
// reset: synchronous active-low rst_n clears every stage valid bit; data registers keep contents
// ----------------------------------------------------------------------------
// binary_to_bcd_core
// Pipelined 32-bit binary to packed BCD converter with overflow flag.
// ----------------------------------------------------------------------------
module binary_to_bcd_core
  import b2bcd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [BIN_W-1:0] in_binary_value,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [OUT_W-1:0] out_bcd_value,
  output logic             out_overflow
);

  logic [NUM_STAGES-1:0] vld_r;
  logic [NUM_STAGES-1:0] stage_rdy;
  bcd_t                  bcd_r   [NUM_STAGES];
  bcd_t                  bcd_nxt [NUM_STAGES];
  bin_t                  bin_r   [NUM_STAGES-1];
  bin_t                  bin_nxt [NUM_STAGES-1];

  // a stage takes new data when empty or when its contents move on
  always_comb begin
    stage_rdy[NUM_STAGES-1] = !vld_r[NUM_STAGES-1] || !out_stall;
    for (int s = NUM_STAGES - 2; s >= 0; s--) begin
      stage_rdy[s] = !vld_r[s] || stage_rdy[s+1];
    end
  end

  assign in_stall = !stage_rdy[0];

  for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
    if (s == 0) begin : g_first
      always_comb begin
        bcd_nxt[s] = dd_step('0, in_binary_value[BIN_W-1 -: STEP_BITS]);
        bin_nxt[s] = in_binary_value << STEP_BITS;
      end
      always_ff @(posedge clk) begin
        if (stage_rdy[s]) begin
          bcd_r[s] <= bcd_nxt[s];
          bin_r[s] <= bin_nxt[s];
        end
      end
    end else if (s == NUM_STAGES - 1) begin : g_last
      always_comb begin
        bcd_nxt[s] = dd_step(bcd_r[s-1], bin_r[s-1][BIN_W-1 -: STEP_BITS]);
      end
      always_ff @(posedge clk) begin
        if (stage_rdy[s]) begin
          bcd_r[s] <= bcd_nxt[s];
        end
      end
    end else begin : g_mid
      always_comb begin
        bcd_nxt[s] = dd_step(bcd_r[s-1], bin_r[s-1][BIN_W-1 -: STEP_BITS]);
        bin_nxt[s] = bin_r[s-1] << STEP_BITS;
      end
      always_ff @(posedge clk) begin
        if (stage_rdy[s]) begin
          bcd_r[s] <= bcd_nxt[s];
          bin_r[s] <= bin_nxt[s];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (stage_rdy[s]) begin
        vld_r[s] <= (s == 0) ? in_valid : vld_r[(s == 0) ? 0 : s - 1];
      end
    end
  end

  assign out_valid     = vld_r[NUM_STAGES-1];
  assign out_bcd_value = OUT_W'(bcd_r[NUM_STAGES-1][KEPT_W-1:0]);
  // any nonzero digit above the kept ones means the value did not fit
  assign out_overflow  = |(bcd_r[NUM_STAGES-1] >> KEPT_W);

endmodule

// ===== rtl/core/b2bcd_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2bcd_chk
// Port-level checks for the binary to BCD converter, bound to binary_to_bcd_core.
// ----------------------------------------------------------------------------
module b2bcd_chk
  import b2bcd_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic [BIN_W-1:0] in_binary_value,
  input logic             out_valid,
  input logic             out_stall,
  input logic [OUT_W-1:0] out_bcd_value,
  input logic             out_overflow
);

  logic digits_ok;

  always_comb begin
    digits_ok = 1'b1;
    for (int d = 0; d < OUT_W / 4; d++) begin
      if (out_bcd_value[4*d +: 4] > 4'd9) begin
        digits_ok = 1'b0;
      end
    end
  end

  // a stalled input transfer keeps its value
  a_in_stable: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_binary_value))
    else $error("input changed while stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_bcd_value) && $stable(out_overflow))
    else $error("result changed while stalled");

  a_digits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> digits_ok)
    else $error("result nibble is not a decimal digit");

  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while output drains freely");

endmodule

bind binary_to_bcd_core b2bcd_chk u_b2bcd_chk (.*);
